// ===== hdl/skvt_pkg.sv =====
// Package for the sorted key/value table: sizes, request and status codes,
// and the beat and memory port types. Depends on nothing.
package skvt_pkg;

    // Table depth and the widths derived from it.
    localparam int DEPTH  = 128;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int CMP_W  = (CNT_W > 8) ? CNT_W : 8;

    // Configuration register indexes.
    localparam int          CFG_IDX_W       = 4;
    localparam logic [3:0]  CFG_CAPACITY    = 4'd0;
    localparam logic [3:0]  CFG_DEFAULT_VAL = 4'd1;
    localparam logic [7:0]  CAPACITY_RESET  = 8'd128;

    // Request kinds.
    localparam logic [1:0] REQ_LOOKUP = 2'd0;
    localparam logic [1:0] REQ_SET    = 2'd1;
    localparam logic [1:0] REQ_DELETE = 2'd2;
    localparam logic [1:0] REQ_CLEAR  = 2'd3;

    // Result status codes.
    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_FULL   = 2'd1;
    localparam logic [1:0] ST_ABSENT = 2'd2;

    typedef struct packed {
        logic [1:0]         req_type;
        logic signed [31:0] key;
        logic signed [31:0] value;
    } t_req;

    typedef struct packed {
        logic signed [31:0] read_value;
        logic               found;
        logic [1:0]         status;
        logic [7:0]         entry_count;
    } t_rsp;

    // One table entry as stored in memory.
    typedef struct packed {
        logic signed [31:0] key;
        logic signed [31:0] value;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    // Memory port requests issued by the engine.
    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        t_entry            wdata;
        logic              re;
        logic [ADDR_W-1:0] raddr;
    } t_mem_req;

endpackage

// ===== hdl/skvt_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Depends on nothing.
module skvt_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 128
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic                                   i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read port; the read data is registered.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

// ===== hdl/skvt_engine.sv =====
// Request engine: binary search over the entry memory, shift up on insert,
// shift down on delete, entry count. Depends on skvt_pkg.
module skvt_engine
    import skvt_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  t_req               i_req,
    input  logic [7:0]         i_capacity,
    input  logic signed [31:0] i_default_value,
    output logic               o_idle,
    output logic               o_res_valid,
    input  logic               i_res_take,
    output t_rsp               o_res,
    output t_mem_req           o_mem,
    input  t_entry             i_rdata
);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_SRCH   = 4'd1;
    localparam logic [3:0] S_CMP    = 4'd2;
    localparam logic [3:0] S_DECIDE = 4'd3;
    localparam logic [3:0] S_SHUP   = 4'd4;
    localparam logic [3:0] S_INSW   = 4'd5;
    localparam logic [3:0] S_SHDN   = 4'd6;
    localparam logic [3:0] S_DONE   = 4'd7;

    logic [3:0]         r_state, n_state;
    t_req               r_req, n_req;
    logic [CNT_W-1:0]   r_lo, n_lo;
    logic [CNT_W-1:0]   r_hi, n_hi;
    logic [CNT_W-1:0]   r_mid, n_mid;
    logic               r_hit, n_hit;
    logic signed [31:0] r_hitval, n_hitval;
    logic [CNT_W-1:0]   r_idx, n_idx;
    logic               r_pend, n_pend;
    logic [ADDR_W-1:0]  r_pdst, n_pdst;
    logic [CNT_W-1:0]   r_used, n_used;
    logic signed [31:0] r_rd, n_rd;
    logic               r_found, n_found;
    logic [1:0]         r_status, n_status;

    logic [CNT_W-1:0] mid;
    logic [CMP_W-1:0] limit;
    logic [CMP_W-1:0] used_ext;
    logic             full;

    // Midpoint of the current search window and the effective entry limit.
    assign mid      = r_lo + ((r_hi - r_lo) >> 1);
    assign used_ext = CMP_W'(r_used);
    assign limit    = (CMP_W'(i_capacity) > CMP_W'(DEPTH)) ? CMP_W'(DEPTH)
                                                           : CMP_W'(i_capacity);
    assign full     = (used_ext >= limit);

    assign o_idle      = (r_state == S_IDLE);
    assign o_res_valid = (r_state == S_DONE);

    // Result fields; the count is the table size after the request.
    always_comb begin
        o_res.read_value  = r_rd;
        o_res.found       = r_found;
        o_res.status      = r_status;
        o_res.entry_count = 8'(r_used);
    end

    // Control and memory sequencing.
    always_comb begin
        n_state  = r_state;
        n_req    = r_req;
        n_lo     = r_lo;
        n_hi     = r_hi;
        n_mid    = r_mid;
        n_hit    = r_hit;
        n_hitval = r_hitval;
        n_idx    = r_idx;
        n_pend   = r_pend;
        n_pdst   = r_pdst;
        n_used   = r_used;
        n_rd     = r_rd;
        n_found  = r_found;
        n_status = r_status;

        o_mem.we    = 1'b0;
        o_mem.waddr = r_pdst;
        o_mem.wdata = i_rdata;
        o_mem.re    = 1'b0;
        o_mem.raddr = mid[ADDR_W-1:0];

        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_req    = i_req;
                    n_rd     = '0;
                    n_found  = 1'b0;
                    n_status = ST_OK;
                    n_hit    = 1'b0;
                    n_lo     = '0;
                    n_hi     = r_used;
                    if (i_req.req_type == REQ_CLEAR) begin
                        n_used  = '0;
                        n_state = S_DONE;
                    end else begin
                        n_state = S_SRCH;
                    end
                end
            end

            // Issue the read of the midpoint, or end the search on an empty window.
            S_SRCH: begin
                if (r_lo < r_hi) begin
                    o_mem.re = 1'b1;
                    n_mid    = mid;
                    n_state  = S_CMP;
                end else begin
                    n_state = S_DECIDE;
                end
            end

            // Narrow the window by the key read back from memory.
            S_CMP: begin
                if (i_rdata.key == r_req.key) begin
                    n_hit    = 1'b1;
                    n_hitval = i_rdata.value;
                    n_lo     = r_mid;
                    n_state  = S_DECIDE;
                end else if (i_rdata.key < r_req.key) begin
                    n_lo    = r_mid + 1'b1;
                    n_state = S_SRCH;
                end else begin
                    n_hi    = r_mid;
                    n_state = S_SRCH;
                end
            end

            // The position is in r_lo: the match or the insertion point.
            S_DECIDE: begin
                n_found = r_hit;
                n_pend  = 1'b0;
                n_state = S_DONE;
                case (r_req.req_type)
                    REQ_LOOKUP: begin
                        n_rd = r_hit ? r_hitval : i_default_value;
                    end
                    REQ_SET: begin
                        if (r_hit) begin
                            o_mem.we    = 1'b1;
                            o_mem.waddr = r_lo[ADDR_W-1:0];
                            o_mem.wdata = '{key: r_req.key, value: r_req.value};
                        end else if (full) begin
                            n_status = ST_FULL;
                        end else begin
                            n_idx   = r_used;
                            n_state = S_SHUP;
                        end
                    end
                    REQ_DELETE: begin
                        if (r_hit) begin
                            n_idx   = r_lo + 1'b1;
                            n_state = S_SHDN;
                        end else begin
                            n_status = ST_ABSENT;
                        end
                    end
                    default: begin
                        n_state = S_DONE;
                    end
                endcase
            end

            // Move entries up one place, top first; the read of one entry
            // overlaps the write of the one above it.
            S_SHUP: begin
                o_mem.we = r_pend;
                if (r_idx > r_lo) begin
                    o_mem.re    = 1'b1;
                    o_mem.raddr = ADDR_W'(r_idx - 1'b1);
                    n_pend      = 1'b1;
                    n_pdst      = r_idx[ADDR_W-1:0];
                    n_idx       = r_idx - 1'b1;
                end else begin
                    n_pend  = 1'b0;
                    n_state = S_INSW;
                end
            end

            // Write the new entry into the opened slot.
            S_INSW: begin
                o_mem.we    = 1'b1;
                o_mem.waddr = r_lo[ADDR_W-1:0];
                o_mem.wdata = '{key: r_req.key, value: r_req.value};
                n_used      = r_used + 1'b1;
                n_state     = S_DONE;
            end

            // Move the entries above the deleted one down one place.
            S_SHDN: begin
                o_mem.we = r_pend;
                if (r_idx < r_used) begin
                    o_mem.re    = 1'b1;
                    o_mem.raddr = r_idx[ADDR_W-1:0];
                    n_pend      = 1'b1;
                    n_pdst      = ADDR_W'(r_idx - 1'b1);
                    n_idx       = r_idx + 1'b1;
                end else begin
                    n_pend  = 1'b0;
                    n_used  = r_used - 1'b1;
                    n_state = S_DONE;
                end
            end

            // Hold the result until the output register takes it.
            S_DONE: begin
                if (i_res_take) begin
                    n_state = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_used  <= '0;
            r_pend  <= 1'b0;
            r_lo    <= '0;
            r_hi    <= '0;
        end else begin
            r_state <= n_state;
            r_used  <= n_used;
            r_pend  <= n_pend;
            r_lo    <= n_lo;
            r_hi    <= n_hi;
        end
    end

    // Working registers of the current request.
    always_ff @(posedge i_clk) begin
        r_req    <= n_req;
        r_mid    <= n_mid;
        r_hit    <= n_hit;
        r_hitval <= n_hitval;
        r_idx    <= n_idx;
        r_pdst   <= n_pdst;
        r_rd     <= n_rd;
        r_found  <= n_found;
        r_status <= n_status;
    end

`ifndef SYNTH
    // The entry count never passes the depth of the memory.
    a_used_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_used <= CNT_W'(DEPTH))
        else $error("entry count above depth");

    // A shift never writes the entry it reads in the same cycle.
    a_no_collision: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_mem.we && o_mem.re) |-> (o_mem.waddr != o_mem.raddr))
        else $error("read and write of one entry in one cycle");

    // The search window stays ordered and inside the used entries.
    a_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SRCH || r_state == S_CMP) |-> (r_lo <= r_hi && r_hi <= r_used))
        else $error("search window out of order");

    // An insert grows the table by exactly one entry.
    a_insert_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_INSW) |=> (r_used == $past(r_used) + 1'b1))
        else $error("insert did not add one entry");
`endif

endmodule

// ===== hdl/sorted_key_value_table.sv =====
// Top level of the sorted key/value table: configuration registers, output
// register, engine and entry memory. Depends on skvt_pkg, skvt_engine, skvt_ram.
//
//  channel   direction  handshake                      beat
//  in        sink       i_in_valid / o_in_ready        i_in_data   (t_req)
//  out       source     o_out_valid / i_out_ready      o_out_data  (t_rsp)
//  cfg       sink       i_cfg_valid / o_cfg_ready      i_cfg_index, i_cfg_data
//
// One request is worked at a time. A clear empties the table without a search.
// A lookup is a binary search of up to 8 steps at 128 entries, each step a
// read of the midpoint through the single read port and a compare; an insert
// then shifts the entries above the insertion point up, and a delete shifts
// those above the deleted entry down. Reset is synchronous, active low, and
// empties the table at once. A result waits in the output register while the
// next request is taken; a stalled output only holds the engine at its end.
module sorted_key_value_table
    import skvt_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  t_req                 i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output t_rsp                 o_out_data,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [31:0]          i_cfg_data
);

    logic [7:0]         r_capacity;
    logic signed [31:0] r_default_value;
    logic               r_out_valid;
    t_rsp               r_out_data;

    logic     eng_idle;
    logic     eng_res_valid;
    logic     res_take;
    t_rsp     eng_res;
    t_mem_req mem_req;
    t_entry   mem_rdata;

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = eng_idle;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    // The output register takes a result whenever it is empty or being drained.
    assign res_take = eng_res_valid && (!r_out_valid || i_out_ready);

    // Configuration registers; unknown indexes are ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity      <= CAPACITY_RESET;
            r_default_value <= '0;
        end else if (i_cfg_valid) begin
            if (i_cfg_index == CFG_CAPACITY) begin
                r_capacity <= i_cfg_data[7:0];
            end else if (i_cfg_index == CFG_DEFAULT_VAL) begin
                r_default_value <= i_cfg_data;
            end
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_take) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_take) begin
            r_out_data <= eng_res;
        end
    end

    skvt_engine u_engine (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_start         (i_in_valid && eng_idle),
        .i_req           (i_in_data),
        .i_capacity      (r_capacity),
        .i_default_value (r_default_value),
        .o_idle          (eng_idle),
        .o_res_valid     (eng_res_valid),
        .i_res_take      (res_take),
        .o_res           (eng_res),
        .o_mem           (mem_req),
        .i_rdata         (mem_rdata)
    );

    skvt_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (mem_req.we),
        .i_waddr (mem_req.waddr),
        .i_wdata (mem_req.wdata),
        .i_re    (mem_req.re),
        .i_raddr (mem_req.raddr),
        .o_rdata (mem_rdata)
    );

endmodule
